// ===== rtl/core/ect_pkg.sv =====
// ect_pkg: shared types, codes and small tables for the edge contour tracer.
// Used by the tracer top level and its neighbor scoring stage.
package ect_pkg;

   // internal coordinate width; the size registers are 7 bits wide
   localparam int CW   = 7;
   localparam int CMAX = (2 ** CW) - 1;
   // score width: direction term up to +/-32768 plus two Q2.14 products
   localparam int SW   = 19;

   // operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_POINT   = 2'd0;
   localparam logic [1:0] STATUS_CLOSED  = 2'd1;
   localparam logic [1:0] STATUS_NO_EDGE = 2'd2;
   localparam logic [1:0] STATUS_NO_NBR  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [6:0] WIDTH_RESET     = 7'd64;
   localparam logic [6:0] HEIGHT_RESET    = 7'd64;
   localparam logic [7:0] THRESHOLD_RESET = 8'd3;

   // direction packing {dy, dx}, each 2-bit two's complement; (0,-1) is "up"
   localparam logic [3:0] DIR_UP = 4'b1100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NBR,
      ST_RESP
   } state_type;

   // registered output of the neighbor scoring stage
   typedef struct packed {
      logic                 valid;
      logic [2:0]           idx;
      logic                 hit;
      logic signed [SW-1:0] score;
      logic [15:0]          normal;
   } score_type;

   // neighbor visiting order, x offsets
   function automatic logic [1:0] nb_dx(input logic [2:0] idx);
      case (idx)
         3'd0: nb_dx = 2'b00;
         3'd1: nb_dx = 2'b00;
         3'd2: nb_dx = 2'b01;
         3'd3: nb_dx = 2'b01;
         3'd4: nb_dx = 2'b01;
         3'd5: nb_dx = 2'b11;
         3'd6: nb_dx = 2'b11;
         default: nb_dx = 2'b11;
      endcase
   endfunction

   // neighbor visiting order, y offsets
   function automatic logic [1:0] nb_dy(input logic [2:0] idx);
      case (idx)
         3'd0: nb_dy = 2'b01;
         3'd1: nb_dy = 2'b11;
         3'd2: nb_dy = 2'b00;
         3'd3: nb_dy = 2'b01;
         3'd4: nb_dy = 2'b11;
         3'd5: nb_dy = 2'b01;
         3'd6: nb_dy = 2'b00;
         default: nb_dy = 2'b11;
      endcase
   endfunction

   // probe row for pass k of the start search: floor(h * m / 8)
   function automatic logic [CW-1:0] probe_row(input logic [CW-1:0] h,
                                               input logic [2:0] k);
      logic [2:0]    m;
      logic [CW+2:0] prod;
      case (k)
         3'd0: m = 3'd4;
         3'd1: m = 3'd2;
         3'd2: m = 3'd6;
         3'd3: m = 3'd1;
         3'd4: m = 3'd3;
         3'd5: m = 3'd5;
         3'd6: m = 3'd7;
         default: m = 3'd0;
      endcase
      prod = (CW+3)'(h) * (CW+3)'(m);
      probe_row = prod[CW+2:3];
   endfunction

endpackage

// ===== rtl/core/ect_ram.sv =====
// ect_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module ect_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/ect_scorer.sv =====
// ect_scorer: one registered stage that tests a neighbor pixel for edge and
// scores it against the last direction and normal. Depends on ect_pkg.
module ect_scorer import ect_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [2:0]  in_idx,
   input  logic        in_inb,
   input  logic [23:0] entry,
   input  logic [7:0]  threshold,
   input  logic [3:0]  last_dir,
   input  logic [15:0] last_norm,
   output score_type   sc
);

   logic                 valid_ff;
   logic [2:0]           idx_ff;
   logic                 hit_ff;
   logic signed [SW-1:0] score_ff;
   logic [15:0]          normal_ff;

   logic [1:0]           dx, dy;
   logic signed [3:0]    dxe, dye, ldxe, ldye, dot;
   logic signed [15:0]   p_x, p_y;
   logic signed [SW-1:0] dterm, score_in;
   logic                 hit_in;

   // direction dot product, weighted by 2^14, plus normal dot product
   always_comb begin
      dx    = nb_dx(in_idx);
      dy    = nb_dy(in_idx);
      dxe   = {{2{dx[1]}}, dx};
      dye   = {{2{dy[1]}}, dy};
      ldxe  = {{2{last_dir[1]}}, last_dir[1:0]};
      ldye  = {{2{last_dir[3]}}, last_dir[3:2]};
      dot   = dxe * ldxe + dye * ldye;
      dterm = {{(SW-18){dot[3]}}, dot, 14'd0};
      p_x   = $signed(entry[15:8]) * $signed(last_norm[7:0]);
      p_y   = $signed(entry[23:16]) * $signed(last_norm[15:8]);
      score_in = dterm + SW'(p_x) + SW'(p_y);
      hit_in   = in_inb && (entry[7:0] > threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= in_idx;
      hit_ff    <= hit_in;
      score_ff  <= score_in;
      normal_ff <= entry[23:8];
   end

   assign sc = '{valid: valid_ff, idx: idx_ff, hit: hit_ff,
                 score: score_ff, normal: normal_ff};

endmodule

// ===== rtl/core/edge_contour_tracer.sv =====
// edge_contour_tracer: edge image store with start search and contour stepping.
// Load: written into the pixel RAM, no result. Advance: the result follows
// eight neighbor reads from the pixel RAM's single read port; inactive: no reads, status NO_EDGE.
// Start: scans until an edge pixel is found or the scan ends; input stalls till done.
// Reset clears control and trace state and sets size 64x64, threshold 3;
// the pixel RAM is not cleared. Depends on ect_pkg, ect_ram, ect_scorer.
module edge_contour_tracer import ect_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [5:0]        req_pixel_x,
   input  logic [5:0]        req_pixel_y,
   input  logic [7:0]        req_edge_strength,
   input  logic signed [7:0] req_normal_x,
   input  logic signed [7:0] req_normal_y,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [5:0]        rsp_point_x,
   output logic [5:0]        rsp_point_y,
   output logic [1:0]        rsp_status,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam logic [CW-1:0] W_CAP = CW'((MAX_WIDTH > CMAX) ? CMAX : MAX_WIDTH);
   localparam logic [CW-1:0] H_CAP = CW'((MAX_HEIGHT > CMAX) ? CMAX : MAX_HEIGHT);

   // registers
   state_type            state_ff, state_in;
   logic [6:0]           width_ff, height_ff;
   logic [7:0]           thr_ff;
   logic [CW-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]        start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [15:0]          lnorm_ff, lnorm_in;
   logic [3:0]           ldir_ff, ldir_in;
   logic                 active_ff, active_in;
   // start search
   logic [CW-1:0]        ix_ff, ix_in, iy_ff, iy_in;
   logic [2:0]           phase_ff, phase_in;
   logic                 more_ff, more_in;
   logic                 pv_ff, pv_in;
   logic [CW-1:0]        px_ff, px_in, py_ff, py_in;
   // neighbor pass
   logic [3:0]           nb_cnt_ff, nb_cnt_in;
   logic                 rv_ff, rv_in;
   logic [2:0]           ridx_ff, ridx_in;
   logic                 rinb_ff, rinb_in;
   logic                 bfound_ff, bfound_in;
   logic [2:0]           bidx_ff, bidx_in;
   logic signed [SW-1:0] bscore_ff, bscore_in;
   logic [15:0]          bnorm_ff, bnorm_in;
   // pending and output result
   logic [5:0]           pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [1:0]           pend_st_ff, pend_st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]           rsp_st_ff, rsp_st_in;

   // combinational
   logic                 req_accept;
   logic [CW-1:0]        eff_w, eff_h;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [23:0]          ram_rd_data;
   logic                 scan_hit;
   logic [1:0]           ndx, ndy, mdx, mdy;
   logic [8:0]           nx, ny;
   logic                 n_inb;
   logic [CW-1:0]        mv_x, mv_y;
   score_type            sc;

   function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
      pix_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;

   // effective image size, clipped to the store
   assign eff_w = (width_ff > W_CAP) ? W_CAP : width_ff;
   assign eff_h = (height_ff > H_CAP) ? H_CAP : height_ff;

   // pixel load path
   assign ram_wr_en   = req_accept && (req_operation == OP_LOAD) &&
                        (int'(req_pixel_x) < MAX_WIDTH) &&
                        (int'(req_pixel_y) < MAX_HEIGHT);
   assign ram_wr_addr = pix_addr(CW'(req_pixel_x), CW'(req_pixel_y));

   ect_ram #(
      .WIDTH (24),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_pixels (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_normal_y, req_normal_x, req_edge_strength}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ect_scorer u_scorer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rv_ff),
      .in_idx    (ridx_ff),
      .in_inb    (rinb_ff),
      .entry     (ram_rd_data),
      .threshold (thr_ff),
      .last_dir  (ldir_ff),
      .last_norm (lnorm_ff),
      .sc        (sc)
   );

   // neighbor address and bounds for the next read
   always_comb begin
      ndx   = nb_dx(nb_cnt_ff[2:0]);
      ndy   = nb_dy(nb_cnt_ff[2:0]);
      nx    = {2'b00, cur_x_ff} + {{7{ndx[1]}}, ndx};
      ny    = {2'b00, cur_y_ff} + {{7{ndy[1]}}, ndy};
      n_inb = !nx[8] && !ny[8] && (nx[7:0] < {1'b0, eff_w}) &&
              (ny[7:0] < {1'b0, eff_h});
   end

   assign scan_hit = pv_ff && (ram_rd_data[7:0] > thr_ff);

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      lnorm_in     = lnorm_ff;
      ldir_in      = ldir_ff;
      active_in    = active_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      phase_in     = phase_ff;
      more_in      = more_ff;
      pv_in        = 1'b0;
      px_in        = px_ff;
      py_in        = py_ff;
      nb_cnt_in    = nb_cnt_ff;
      rv_in        = 1'b0;
      ridx_in      = ridx_ff;
      rinb_in      = rinb_ff;
      bfound_in    = bfound_ff;
      bidx_in      = bidx_ff;
      bscore_in    = bscore_ff;
      bnorm_in     = bnorm_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      pend_st_in   = pend_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_st_in    = rsp_st_ff;
      ram_rd_addr  = pix_addr(ix_ff, iy_ff);
      mdx          = nb_dx(3'd0);
      mdy          = nb_dy(3'd0);
      mv_x         = cur_x_ff;
      mv_y         = cur_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_operation)
                  OP_START: begin
                     if (eff_w == '0 || eff_h == '0) begin
                        active_in  = 1'b0;
                        pend_x_in  = '0;
                        pend_y_in  = '0;
                        pend_st_in = STATUS_NO_EDGE;
                        state_in   = ST_RESP;
                     end else begin
                        ix_in    = '0;
                        iy_in    = probe_row(eff_h, 3'd0);
                        phase_in = 3'd0;
                        more_in  = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_ADVANCE: begin
                     if (!active_ff) begin
                        pend_x_in  = '0;
                        pend_y_in  = '0;
                        pend_st_in = STATUS_NO_EDGE;
                        state_in   = ST_RESP;
                     end else begin
                        nb_cnt_in = '0;
                        bfound_in = 1'b0;
                        bscore_in = '0;
                        state_in  = ST_NBR;
                     end
                  end
                  default: begin
                     // loads go straight to the RAM; code 3 is dropped
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (scan_hit) begin
               // first edge pixel in scan order becomes the start
               start_x_in = px_ff;
               start_y_in = py_ff;
               cur_x_in   = px_ff;
               cur_y_in   = py_ff;
               lnorm_in   = ram_rd_data[23:8];
               ldir_in    = DIR_UP;
               active_in  = 1'b1;
               pend_x_in  = px_ff[5:0];
               pend_y_in  = py_ff[5:0];
               pend_st_in = STATUS_POINT;
               state_in   = ST_RESP;
            end else if (more_ff) begin
               // read one pixel, then step the scan pointer
               pv_in = 1'b1;
               px_in = ix_ff;
               py_in = iy_ff;
               if (({1'b0, ix_ff} + 8'd1) < {1'b0, eff_w}) begin
                  ix_in = ix_ff + 1'b1;
               end else begin
                  ix_in = '0;
                  if (phase_ff < 3'd6) begin
                     phase_in = phase_ff + 1'b1;
                     iy_in    = probe_row(eff_h, phase_ff + 1'b1);
                  end else if (phase_ff == 3'd6) begin
                     phase_in = 3'd7;
                     iy_in    = '0;
                  end else if (({1'b0, iy_ff} + 8'd1) < {1'b0, eff_h}) begin
                     iy_in = iy_ff + 1'b1;
                  end else begin
                     more_in = 1'b0;
                  end
               end
            end else if (!pv_ff) begin
               active_in  = 1'b0;
               pend_x_in  = '0;
               pend_y_in  = '0;
               pend_st_in = STATUS_NO_EDGE;
               state_in   = ST_RESP;
            end
         end

         ST_NBR: begin
            // issue one neighbor read per cycle
            ram_rd_addr = pix_addr(nx[CW-1:0], ny[CW-1:0]);
            if (!nb_cnt_ff[3]) begin
               rv_in     = 1'b1;
               ridx_in   = nb_cnt_ff[2:0];
               rinb_in   = n_inb;
               nb_cnt_in = nb_cnt_ff + 1'b1;
            end
            // keep first edge neighbor, replace on a score strictly above max(0, best score)
            if (sc.valid && sc.hit) begin
               if (!bfound_ff) begin
                  bfound_in = 1'b1;
                  bidx_in   = sc.idx;
                  bnorm_in  = sc.normal;
               end
               if (sc.score > bscore_ff) begin
                  bscore_in = sc.score;
                  bidx_in   = sc.idx;
                  bnorm_in  = sc.normal;
               end
            end
            // last neighbor scored: move or stop
            if (sc.valid && sc.idx == 3'd7) begin
               mdx  = nb_dx(bidx_in);
               mdy  = nb_dy(bidx_in);
               mv_x = cur_x_ff + {{(CW-2){mdx[1]}}, mdx};
               mv_y = cur_y_ff + {{(CW-2){mdy[1]}}, mdy};
               state_in = ST_RESP;
               if (!bfound_in) begin
                  active_in  = 1'b0;
                  pend_x_in  = cur_x_ff[5:0];
                  pend_y_in  = cur_y_ff[5:0];
                  pend_st_in = STATUS_NO_NBR;
               end else begin
                  cur_x_in   = mv_x;
                  cur_y_in   = mv_y;
                  ldir_in    = {mdy, mdx};
                  lnorm_in   = bnorm_in;
                  pend_x_in  = mv_x[5:0];
                  pend_y_in  = mv_y[5:0];
                  if (mv_x == start_x_ff && mv_y == start_y_ff) begin
                     active_in  = 1'b0;
                     pend_st_in = STATUS_CLOSED;
                  end else begin
                     pend_st_in = STATUS_POINT;
                  end
               end
            end
         end

         ST_RESP: begin
            // move the result into the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_st_in    = pend_st_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and trace registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         thr_ff       <= THRESHOLD_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         lnorm_ff     <= '0;
         ldir_ff      <= DIR_UP;
         active_ff    <= 1'b0;
         more_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         nb_cnt_ff    <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:     width_ff  <= csr_data[6:0];
               CSR_HEIGHT:    height_ff <= csr_data[6:0];
               CSR_THRESHOLD: thr_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         lnorm_ff     <= lnorm_in;
         ldir_ff      <= ldir_in;
         active_ff    <= active_in;
         more_ff      <= more_in;
         pv_ff        <= pv_in;
         nb_cnt_ff    <= nb_cnt_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      phase_ff   <= phase_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      ridx_ff    <= ridx_in;
      rinb_ff    <= rinb_in;
      bfound_ff  <= bfound_in;
      bidx_ff    <= bidx_in;
      bscore_ff  <= bscore_in;
      bnorm_ff   <= bnorm_in;
      pend_x_ff  <= pend_x_in;
      pend_y_ff  <= pend_y_in;
      pend_st_ff <= pend_st_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_status  = rsp_st_ff;

   // neighbor reads and scores only occur during a trace step
   a_read_in_step: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == ST_NBR)
      else $error("neighbor read outside trace step");

   a_score_in_step: assert property (@(posedge clock) disable iff (reset)
      sc.valid |-> state_ff == ST_NBR)
      else $error("neighbor score outside trace step");

   // a new result only comes from the result hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result raised without pending result");

   // any terminating status leaves the trace inactive
   a_stop_inactive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && pend_st_ff != STATUS_POINT) |-> !active_ff)
      else $error("trace still active after terminating status");

endmodule
